@@ rtl/ibot_pkg.sv @@
// Shared types and defaults for the interval booking overlap table.
`default_nettype none
package ibot_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int TIME_BITS_DEF = 32;

    typedef struct packed {
        logic [TIME_BITS_DEF-1:0] start_time;
        logic [TIME_BITS_DEF-1:0] end_time;
    } req_t;

    typedef struct packed {
        logic booked;
        logic table_full;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture request, restart scan
        logic rd;     // read entry at scan index, advance index
        logic emit;   // decide, write on success, load result register
    } ibot_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;
        logic last_idx;
    } ibot_sts_t;

endpackage
`default_nettype wire

@@ rtl/ibot_datapath.sv @@
// Datapath: interval memories, entry count, scan pipeline and result register.
`default_nettype none
module ibot_datapath #(
    parameter int ENTRIES   = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ibot_pkg::req_t    req,
    input  wire ibot_pkg::ibot_cmd_t cmd,
    output ibot_pkg::ibot_sts_t    sts,
    output ibot_pkg::rsp_t         rsp
);
    import ibot_pkg::*;

    localparam int TIME_BITS = TIME_BITS_DEF;
    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    logic [TIME_BITS-1:0] start_mem [ENTRIES];
    logic [TIME_BITS-1:0] end_mem   [ENTRIES];

    logic [TIME_BITS-1:0] s_reg, e_reg;
    logic [TIME_BITS-1:0] rd_start_reg, rd_end_reg;
    logic                 rdv_reg;
    logic                 conflict_reg;
    logic [ADDR_W-1:0]    idx_reg;
    logic [CNT_W-1:0]     count_reg;
    rsp_t                 rsp_reg;

    logic hit;
    logic full;
    logic book;

    assign hit  = rdv_reg && (rd_start_reg < e_reg) && (s_reg < rd_end_reg);
    assign full = (count_reg == CNT_W'(ENTRIES));
    assign book = !conflict_reg && !full;

    assign sts.count_zero = (count_reg == '0);
    assign sts.last_idx   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign rsp            = rsp_reg;

    // single write port at the fill point, single registered read port at the scan index
    always_ff @(posedge aclk) begin
        if (cmd.emit && book) begin
            start_mem[count_reg[ADDR_W-1:0]] <= s_reg;
            end_mem[count_reg[ADDR_W-1:0]]   <= e_reg;
        end
        if (cmd.rd) begin
            rd_start_reg <= start_mem[idx_reg];
            rd_end_reg   <= end_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            s_reg <= TIME_BITS'(req.start_time);
            e_reg <= TIME_BITS'(req.end_time);
        end
        if (cmd.emit) begin
            rsp_reg.booked     <= book;
            rsp_reg.table_full <= !conflict_reg && full;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            idx_reg      <= '0;
            rdv_reg      <= 1'b0;
            conflict_reg <= 1'b0;
        end else begin
            rdv_reg <= cmd.rd;
            if (cmd.load) begin
                idx_reg      <= '0;
                conflict_reg <= 1'b0;
            end else begin
                if (cmd.rd) begin
                    idx_reg <= idx_reg + ADDR_W'(1);
                end
                if (hit) begin
                    conflict_reg <= 1'b1;
                end
            end
            if (cmd.emit && book) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/ibot_ctrl.sv @@
// Controller: sequences request capture, memory scan, decision and result handoff.
`default_nettype none
module ibot_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire ibot_pkg::ibot_sts_t sts,
    output ibot_pkg::ibot_cmd_t      cmd
);
    import ibot_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign slot_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.count_zero ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.rd = 1'b1;
                if (sts.last_idx) begin
                    state_next = ST_DRAIN;
                end
            end
            // last read's compare folds into the conflict flag
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/interval_booking_overlap_table.sv @@
// Top level of the interval booking overlap table.
//
// Usage:
//   s_valid/s_ready/s_data carry one request item: the half-open interval
//   [start_time, end_time). m_valid/m_ready/m_data return one item per
//   request: booked = 1 when the interval was stored, table_full = 1 when it
//   conflicted with nothing but every entry was in use.
// Timing:
//   Stored intervals live in two memories, each with one write port and one
//   registered read port, scanned one entry per cycle. With N > 0 entries
//   stored, a request passes through one read per entry, a step that folds
//   the last compare and a decide step that writes, and only then can the
//   next be accepted; with the table empty it goes straight to decide.
// Stall:
//   The result sits in an output register; the next request is accepted
//   while it waits. A second result is held in the decide step until the
//   receiver takes the first.
// Reset:
//   aresetn (synchronous, active low) zeroes the entry count; memory is kept.
`default_nettype none
module interval_booking_overlap_table #(
    parameter int ENTRIES   = ibot_pkg::ENTRIES_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire ibot_pkg::req_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output ibot_pkg::rsp_t      m_data
);
    import ibot_pkg::*;

    ibot_cmd_t cmd;
    ibot_sts_t sts;

    ibot_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ibot_datapath #(
        .ENTRIES   (ENTRIES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .rsp     (m_data)
    );

endmodule
`default_nettype wire

@@ rtl/ibot_checker.sv @@
// Port-level checker for the interval booking overlap table, with its bind.
`default_nettype none
module ibot_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire ibot_pkg::rsp_t m_data
);
    import ibot_pkg::*;

    // a held result must not change under a stall
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // full is only reported for a request that was not stored
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.booked && m_data.table_full))
        else $error("booked and table_full both set");

    // one request at a time: busy right after acceptance
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a request while one is in flight");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind interval_booking_overlap_table ibot_checker u_ibot_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
